@@ sv/sfs_pkg.sv @@
// ============================================================================
// sfs_pkg: shared types and constants of the sprite frame sequencer
// Register widths, register indexes and command codes used by the top level
// and its checker.
// ============================================================================
package sfs_pkg;

   // Fixed field widths of the configuration registers and result fields
   localparam int COLS_W      = 9;
   localparam int TOTAL_W     = 13;
   localparam int PERIOD_W    = 24;
   localparam int CELL_W      = 12;
   localparam int LEFT_W      = 20;
   localparam int TOP_W       = 24;
   localparam int OPCODE_W    = 2;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_SHEET_COLUMNS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_TOTAL   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_PERIOD  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_ENABLE   = 3'd5;

   // Command codes
   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK  = 2'd0,
      OP_PLAY  = 2'd1,
      OP_STOP  = 2'd2,
      OP_RESET = 2'd3
   } sfs_opcode_type;

endpackage

@@ sv/sfs_divider.sv @@
// ============================================================================
// sfs_divider: bit-serial restoring divider
// Shifts the dividend in one bit per cycle and builds quotient and remainder
// in place; results hold until the next start.
// The divisor must be nonzero.
// ============================================================================
module sfs_divider #(
   parameter int DD_W = 25,
   parameter int DV_W = 24
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [DD_W-1:0] dividend,
   input  logic [DV_W-1:0] divisor,
   output logic            done,
   output logic [DD_W-1:0] quotient,
   output logic [DV_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DD_W + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DD_W-1:0] work_ff, work_in;
   logic [DV_W-1:0] rem_ff, rem_in;
   logic [DV_W-1:0] divisor_ff, divisor_in;
   logic [DV_W:0]   trial;
   logic            fits;

   // One restoring step: shift next dividend bit into the partial remainder
   assign trial = {rem_ff, work_ff[DD_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = CNT_W'(DD_W);
         work_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         work_in  = {work_ff[DD_W-2:0], fits};
         rem_in   = fits ? DV_W'(trial - {1'b0, divisor_ff}) : trial[DV_W-1:0];
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign quotient  = work_ff;
   assign remainder = rem_ff;

endmodule

@@ sv/sfs_multiplier.sv @@
// ============================================================================
// sfs_multiplier: bit-serial shift-and-add multiplier
// Consumes one multiplier bit per cycle, LSB first, and keeps the low P_W
// bits of the product; result holds until next start.
// ============================================================================
module sfs_multiplier #(
   parameter int A_W = 9,
   parameter int B_W = 12,
   parameter int P_W = 20
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [A_W-1:0] mcand,
   input  logic [B_W-1:0] mplier,
   output logic           done,
   output logic [P_W-1:0] product
);

   localparam int CNT_W = $clog2(B_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [P_W-1:0]   acc_ff, acc_in;
   logic [P_W-1:0]   mcand_ff, mcand_in;
   logic [B_W-1:0]   mplier_ff, mplier_in;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (start) begin
         busy_in   = 1'b1;
         count_in  = CNT_W'(B_W);
         acc_in    = '0;
         mcand_in  = P_W'(mcand);
         mplier_in = mplier;
      end else if (busy_ff) begin
         // add the shifted multiplicand when the current bit is set
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in  = {mcand_ff[P_W-2:0], 1'b0};
         mplier_in = mplier_ff >> 1;
         count_in  = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

@@ sv/sprite_frame_sequencer_top.sv @@
// ============================================================================
// sprite_frame_sequencer_top: sprite-sheet frame animator
// Each request beat is one command (tick, play, stop, reset) and yields one
// response beat with the current frame, its cell origin in the sheet, the
// running flag and a frame-changed flag. Commands are handled one at a time.
// A play, stop, reset or idle tick runs only the column division and the
// multipliers; a running tick with a nonzero delta adds the time division
// first, and when it advances with looping on also the wrap division. One
// shared bit-serial divider is used in turn for elapsed time over the frame
// period, the wrap modulo over the frame total and the frame index over the
// column count, followed by two bit-serial multipliers for the cell origin.
// The response sits in an output register, so the next command is taken
// while it waits.
// ============================================================================
module sprite_frame_sequencer_top #(
   parameter int TIME_BITS  = 24,
   parameter int FRAME_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request: [1:0] opcode, [TIME_BITS+1:2] delta_ticks
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((TIME_BITS+9)/8)*8-1:0]         req_tdata,
   // response: frame_index, rect_left (20), rect_top (24), playing,
   // frame_changed, from the lowest bit up
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((FRAME_BITS+53)/8)*8-1:0]       rsp_tdata,
   // configuration writes
   input  logic                                   csr_we,
   input  logic [sfs_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [sfs_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int RSP_W  = ((FRAME_BITS + 53) / 8) * 8;
   localparam int EW     = TIME_BITS + 1;
   localparam int DD_W   = (EW > FRAME_BITS) ? EW : FRAME_BITS;
   localparam int DV_W   = sfs_pkg::PERIOD_W;
   localparam int CMP_W  = ((FRAME_BITS > sfs_pkg::TOTAL_W) ? FRAME_BITS
                                                            : sfs_pkg::TOTAL_W) + 1;
   localparam int WIDE_W = (DD_W > CMP_W) ? DD_W : CMP_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TIME_DIV,
      ST_WRAP_DIV,
      ST_COL_DIV,
      ST_MULT,
      ST_EMIT
   } state_type;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [sfs_pkg::COLS_W-1:0]   cols_ff, cols_in;
   logic [sfs_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [sfs_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [sfs_pkg::CELL_W-1:0]   width_ff, width_in;
   logic [sfs_pkg::CELL_W-1:0]   height_ff, height_in;
   logic                         loop_ff, loop_in;

   always_comb begin
      cols_in   = cols_ff;
      total_in  = total_ff;
      period_in = period_ff;
      width_in  = width_ff;
      height_in = height_ff;
      loop_in   = loop_ff;
      if (csr_we) begin
         unique case (csr_index)
            sfs_pkg::CSR_SHEET_COLUMNS: cols_in   = csr_wdata[sfs_pkg::COLS_W-1:0];
            sfs_pkg::CSR_FRAME_TOTAL:   total_in  = csr_wdata[sfs_pkg::TOTAL_W-1:0];
            sfs_pkg::CSR_FRAME_PERIOD:  period_in = csr_wdata[sfs_pkg::PERIOD_W-1:0];
            sfs_pkg::CSR_FRAME_WIDTH:   width_in  = csr_wdata[sfs_pkg::CELL_W-1:0];
            sfs_pkg::CSR_FRAME_HEIGHT:  height_in = csr_wdata[sfs_pkg::CELL_W-1:0];
            sfs_pkg::CSR_LOOP_ENABLE:   loop_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff   <= sfs_pkg::COLS_W'(1);
         total_ff  <= sfs_pkg::TOTAL_W'(1);
         period_ff <= sfs_pkg::PERIOD_W'(1);
         width_ff  <= sfs_pkg::CELL_W'(1);
         height_ff <= sfs_pkg::CELL_W'(1);
         loop_ff   <= 1'b0;
      end else begin
         cols_ff   <= cols_in;
         total_ff  <= total_in;
         period_ff <= period_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         loop_ff   <= loop_in;
      end
   end

   // Effective values: zero reads as one, total capped at 2^FRAME_BITS
   logic [sfs_pkg::COLS_W-1:0]   cols_eff;
   logic [sfs_pkg::PERIOD_W-1:0] period_eff;
   logic [CMP_W-1:0]             total_ext;
   logic [CMP_W-1:0]             frame_limit;
   logic [CMP_W-1:0]             total_lim;

   assign cols_eff    = (cols_ff == '0) ? sfs_pkg::COLS_W'(1) : cols_ff;
   assign period_eff  = (period_ff == '0) ? sfs_pkg::PERIOD_W'(1) : period_ff;
   assign total_ext   = (total_ff == '0) ? CMP_W'(1) : CMP_W'(total_ff);
   assign frame_limit = CMP_W'(1) << FRAME_BITS;
   assign total_lim   = (total_ext > frame_limit) ? frame_limit : total_ext;

   // ------------------------------------------------------------------------
   // Request fields
   // ------------------------------------------------------------------------
   sfs_pkg::sfs_opcode_type req_opcode;
   logic [TIME_BITS-1:0]    req_delta;

   assign req_opcode = sfs_pkg::sfs_opcode_type'(req_tdata[sfs_pkg::OPCODE_W-1:0]);
   assign req_delta  = req_tdata[TIME_BITS+sfs_pkg::OPCODE_W-1:sfs_pkg::OPCODE_W];

   // ------------------------------------------------------------------------
   // Shared divider and the two origin multipliers
   // ------------------------------------------------------------------------
   logic              div_start;
   logic [DD_W-1:0]   div_dividend;
   logic [DV_W-1:0]   div_divisor;
   logic              div_done;
   logic [DD_W-1:0]   div_quot;
   logic [DV_W-1:0]   div_rem;

   sfs_divider #(
      .DD_W (DD_W),
      .DV_W (DV_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   logic                        mul_start;
   logic                        mul_left_done;
   logic                        mul_top_done;
   logic [sfs_pkg::LEFT_W-1:0]  left_prod;
   logic [sfs_pkg::TOP_W-1:0]   top_prod;

   // column within the row times cell width
   sfs_multiplier #(
      .A_W (sfs_pkg::COLS_W),
      .B_W (sfs_pkg::CELL_W),
      .P_W (sfs_pkg::LEFT_W)
   ) u_mul_left (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (div_rem[sfs_pkg::COLS_W-1:0]),
      .mplier  (width_ff),
      .done    (mul_left_done),
      .product (left_prod)
   );

   // row number times cell height
   sfs_multiplier #(
      .A_W (FRAME_BITS),
      .B_W (sfs_pkg::CELL_W),
      .P_W (sfs_pkg::TOP_W)
   ) u_mul_top (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (div_quot[FRAME_BITS-1:0]),
      .mplier  (height_ff),
      .done    (mul_top_done),
      .product (top_prod)
   );

   // ------------------------------------------------------------------------
   // Sequencer state
   // ------------------------------------------------------------------------
   state_type                  state_ff, state_in;
   logic [FRAME_BITS-1:0]      frame_ff, frame_in;
   logic [EW-1:0]              elapsed_ff, elapsed_in;
   logic                       running_ff, running_in;
   logic [FRAME_BITS-1:0]      prior_frame_ff, prior_frame_in;
   logic                       wrap_mode_ff, wrap_mode_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [FRAME_BITS-1:0]      out_frame_ff, out_frame_in;
   logic [sfs_pkg::LEFT_W-1:0] out_left_ff, out_left_in;
   logic [sfs_pkg::TOP_W-1:0]  out_top_ff, out_top_in;
   logic                       out_playing_ff, out_playing_in;
   logic                       out_changed_ff, out_changed_in;
   logic                       col_go;

   // Frame arithmetic around the divider results
   logic [EW-1:0]         elapsed_sum;
   logic [WIDE_W-1:0]     steps_w;
   logic [WIDE_W-1:0]     frame_w;
   logic [WIDE_W-1:0]     total_w;
   logic [WIDE_W-1:0]     advance_sum;
   logic                  advance_fits;
   logic                  past_end;
   logic [CMP_W-1:0]      last_frame;
   logic [CMP_W-1:0]      wrap_rem;
   logic [CMP_W-1:0]      wrap_sum;
   logic [CMP_W-1:0]      wrap_fold;

   assign elapsed_sum  = elapsed_ff + EW'(req_delta);
   assign steps_w      = WIDE_W'(div_quot);
   assign frame_w      = WIDE_W'(frame_ff);
   assign total_w      = WIDE_W'(total_lim);
   assign advance_sum  = frame_w + steps_w;
   assign past_end     = frame_w >= total_w;
   assign advance_fits = !past_end && (steps_w <= total_w - frame_w - WIDE_W'(1));
   assign last_frame   = total_lim - CMP_W'(1);
   assign wrap_rem     = CMP_W'(div_rem);
   assign wrap_sum     = CMP_W'(frame_ff) + wrap_rem;
   assign wrap_fold    = (wrap_sum >= total_lim) ? wrap_sum - total_lim : wrap_sum;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      frame_in       = frame_ff;
      elapsed_in     = elapsed_ff;
      running_in     = running_ff;
      prior_frame_in = prior_frame_ff;
      wrap_mode_in   = wrap_mode_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      out_frame_in   = out_frame_ff;
      out_left_in    = out_left_ff;
      out_top_in     = out_top_ff;
      out_playing_in = out_playing_ff;
      out_changed_in = out_changed_ff;
      div_start      = 1'b0;
      div_dividend   = '0;
      div_divisor    = '0;
      mul_start      = 1'b0;
      col_go         = 1'b0;

      unique case (state_ff)
         // take a command; a running tick with a nonzero delta goes to the time division
         ST_IDLE: begin
            if (req_tvalid) begin
               prior_frame_in = frame_ff;
               col_go         = 1'b1;
               unique case (req_opcode)
                  sfs_pkg::OP_TICK: begin
                     if (running_ff && req_delta != '0) begin
                        elapsed_in   = elapsed_sum;
                        div_start    = 1'b1;
                        div_dividend = DD_W'(elapsed_sum);
                        div_divisor  = period_eff;
                        col_go       = 1'b0;
                        state_in     = ST_TIME_DIV;
                     end
                  end
                  sfs_pkg::OP_PLAY: running_in = 1'b1;
                  sfs_pkg::OP_STOP: running_in = 1'b0;
                  sfs_pkg::OP_RESET: begin
                     frame_in   = '0;
                     elapsed_in = '0;
                     running_in = 1'b0;
                  end
               endcase
            end
         end

         // steps and leftover time are ready
         ST_TIME_DIV: begin
            if (div_done) begin
               if (div_quot == '0) begin
                  col_go = 1'b1;
               end else if (loop_ff) begin
                  elapsed_in   = EW'(div_rem);
                  wrap_mode_in = past_end;
                  div_start    = 1'b1;
                  div_dividend = past_end ? div_quot - DD_W'(1) : div_quot;
                  div_divisor  = DV_W'(total_lim);
                  state_in     = ST_WRAP_DIV;
               end else begin
                  if (advance_fits) begin
                     frame_in   = advance_sum[FRAME_BITS-1:0];
                     elapsed_in = EW'(div_rem);
                  end else begin
                     // clamp to the last frame and stop
                     frame_in   = last_frame[FRAME_BITS-1:0];
                     elapsed_in = '0;
                     running_in = 1'b0;
                  end
                  col_go = 1'b1;
               end
            end
         end

         // looping wrap: steps modulo total folded onto the frame, from 0 past the end
         ST_WRAP_DIV: begin
            if (div_done) begin
               frame_in = wrap_mode_ff ? wrap_rem[FRAME_BITS-1:0]
                                       : wrap_fold[FRAME_BITS-1:0];
               col_go   = 1'b1;
            end
         end

         // frame split into row and column; start both origin products
         ST_COL_DIV: begin
            if (div_done) begin
               mul_start = 1'b1;
               state_in  = ST_MULT;
            end
         end

         ST_MULT: begin
            if (mul_left_done && mul_top_done) state_in = ST_EMIT;
         end

         // load the response register once it is free
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               out_frame_in   = frame_ff;
               out_left_in    = left_prod;
               out_top_in     = top_prod;
               out_playing_in = running_ff;
               out_changed_in = frame_ff != prior_frame_ff;
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // column division on the final frame of this command
      if (col_go) begin
         div_start    = 1'b1;
         div_dividend = DD_W'(frame_in);
         div_divisor  = DV_W'(cols_eff);
         state_in     = ST_COL_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frame_ff     <= '0;
         elapsed_ff   <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_ff     <= frame_in;
         elapsed_ff   <= elapsed_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prior_frame_ff <= prior_frame_in;
      wrap_mode_ff   <= wrap_mode_in;
      out_frame_ff   <= out_frame_in;
      out_left_ff    <= out_left_in;
      out_top_ff     <= out_top_in;
      out_playing_ff <= out_playing_in;
      out_changed_ff <= out_changed_in;
   end

   // ------------------------------------------------------------------------
   // Response beat
   // ------------------------------------------------------------------------
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({out_changed_ff, out_playing_ff, out_top_ff,
                               out_left_ff, out_frame_ff});

endmodule

@@ sv/sfs_checker.sv @@
// ============================================================================
// sfs_checker: port-level checks for the sprite frame sequencer
// Watches the top-level ports only; attached to the top level by bind.
// ============================================================================
module sfs_checker #(
   parameter int TIME_BITS  = 24,
   parameter int FRAME_BITS = 12
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [((TIME_BITS+9)/8)*8-1:0]      req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((FRAME_BITS+53)/8)*8-1:0]    rsp_tdata
);

   localparam int LEFT_LO = FRAME_BITS;
   localparam int TOP_LO  = FRAME_BITS + sfs_pkg::LEFT_W;
   localparam int TOP_HI  = TOP_LO + sfs_pkg::TOP_W - 1;

   // a waiting request beat holds its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("request beat changed while waiting");

   // a stalled response beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // no response is pending right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // one command at a time: the block is busy the cycle after a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous command in flight");

   // frame zero sits at the sheet origin
   a_origin_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[FRAME_BITS-1:0] == '0 |->
         rsp_tdata[TOP_LO-1:LEFT_LO] == '0 && rsp_tdata[TOP_HI:TOP_LO] == '0)
      else $error("frame zero with nonzero cell origin");

endmodule

bind sprite_frame_sequencer_top sfs_checker #(
   .TIME_BITS  (TIME_BITS),
   .FRAME_BITS (FRAME_BITS)
) u_sfs_checker (.*);

@@ test/tb_sprite_frame_sequencer_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_sprite_frame_sequencer_top: self-checking bench for the frame sequencer
// Drives play, stop, reset and tick commands, mirrors the animation state in
// a local predictor and compares every response beat field by field. The
// run covers directed corner cases, register extremes, random phases with
// request gaps and response stalls, and a long response hold-off.
// ============================================================================
module tb_sprite_frame_sequencer_top;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int FRAME_SPAN  = 4096;   // 2^FRAME_BITS
   localparam logic [sfs_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;

   // One response beat, frame_index in the lowest bits
   typedef struct packed {
      logic        frame_changed;
      logic        playing;
      logic [23:0] rect_top;
      logic [19:0] rect_left;
      logic [11:0] frame_index;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [1:0] opcode, [25:2] delta_ticks
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // frame_index, rect_left, rect_top, playing,
                                  // frame_changed, from the lowest bit up
   logic                            csr_we = 1'b0;
   logic [sfs_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [sfs_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Register copies, reset values
   logic [8:0]  cfg_columns = 9'd1;
   logic [12:0] cfg_total   = 13'd1;
   logic [23:0] cfg_period  = 24'd1;
   logic [11:0] cfg_width   = 12'd1;
   logic [11:0] cfg_height  = 12'd1;
   logic        cfg_loop    = 1'b0;

   // Animation state copy
   logic [11:0] anim_frame   = '0;
   logic [24:0] anim_elapsed = '0;
   logic        anim_running = 1'b0;

   frame_result_type frame_results_due[$];
   int error_count     = 0;
   int cycle_count     = 0;
   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;
   int rsp_hold_cycles = 0;

   sprite_frame_sequencer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Apply one command to the animation state, return the response it yields
   function automatic frame_result_type step_animation(sfs_pkg::sfs_opcode_type op,
                                                       logic [23:0] delta);
      longint unsigned period, total, cols, steps, rem, frame, left, top;
      logic [11:0] prior;
      frame_result_type r;
      period = (cfg_period == 0) ? 1 : cfg_period;
      total  = (cfg_total == 0) ? 1 : cfg_total;
      if (total > FRAME_SPAN) total = FRAME_SPAN;
      cols   = (cfg_columns == 0) ? 1 : cfg_columns;
      prior  = anim_frame;
      case (op)
         sfs_pkg::OP_TICK: begin
            if (anim_running && delta != 0) begin
               anim_elapsed = anim_elapsed + delta;
               steps = anim_elapsed / period;
               rem   = anim_elapsed % period;
               frame = anim_frame;
               if (steps != 0) begin
                  if (cfg_loop) begin
                     // a frame left past the end by a register write restarts at 0
                     if (frame >= total) frame = (steps - 1) % total;
                     else frame = (frame + steps) % total;
                     anim_elapsed = 25'(rem);
                  end else if (frame < total && steps <= total - 1 - frame) begin
                     frame = frame + steps;
                     anim_elapsed = 25'(rem);
                  end else begin
                     // ran off the end: hold the last frame and stop
                     frame = total - 1;
                     anim_elapsed = '0;
                     anim_running = 1'b0;
                  end
                  anim_frame = frame[11:0];
               end
            end
         end
         sfs_pkg::OP_PLAY: anim_running = 1'b1;
         sfs_pkg::OP_STOP: anim_running = 1'b0;
         default: begin
            anim_frame   = '0;
            anim_elapsed = '0;
            anim_running = 1'b0;
         end
      endcase
      left = (longint'(anim_frame) % cols) * cfg_width;
      top  = (longint'(anim_frame) / cols) * cfg_height;
      r.frame_index   = anim_frame;
      r.rect_left     = left[19:0];
      r.rect_top      = top[23:0];
      r.playing       = anim_running;
      r.frame_changed = (anim_frame != prior);
      return r;
   endfunction

   // Offer one command beat; returns at the edge that accepts it, valid still high
   task automatic send_command(input sfs_pkg::sfs_opcode_type op,
                               input logic [23:0] delta);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, delta, op};
      do @(posedge clock); while (!req_tready);
      frame_results_due.push_back(step_animation(op, delta));
   endtask

   // Drop valid and wait until every response beat has come back
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (frame_results_due.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_register(input logic [sfs_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [sfs_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (index)
         sfs_pkg::CSR_SHEET_COLUMNS: cfg_columns = value[8:0];
         sfs_pkg::CSR_FRAME_TOTAL:   cfg_total   = value[12:0];
         sfs_pkg::CSR_FRAME_PERIOD:  cfg_period  = value[23:0];
         sfs_pkg::CSR_FRAME_WIDTH:   cfg_width   = value[11:0];
         sfs_pkg::CSR_FRAME_HEIGHT:  cfg_height  = value[11:0];
         sfs_pkg::CSR_LOOP_ENABLE:   cfg_loop    = value[0];
         default: ;
      endcase
   endtask

   task automatic write_config(input logic [23:0] cols, input logic [23:0] total,
                               input logic [23:0] period, input logic [23:0] w,
                               input logic [23:0] h, input logic [23:0] loop_en);
      write_register(sfs_pkg::CSR_SHEET_COLUMNS, cols);
      write_register(sfs_pkg::CSR_FRAME_TOTAL, total);
      write_register(sfs_pkg::CSR_FRAME_PERIOD, period);
      write_register(sfs_pkg::CSR_FRAME_WIDTH, w);
      write_register(sfs_pkg::CSR_FRAME_HEIGHT, h);
      write_register(sfs_pkg::CSR_LOOP_ENABLE, loop_en);
   endtask

   // Random settings, mostly short animations; junk sometimes rides above each field but the period
   task automatic load_random_config();
      logic [23:0] cols, total, period, w, h, junk;
      case ($urandom_range(5))
         0:       cols = 0;
         1:       cols = 256;
         2:       cols = 24'($urandom_range(1, 256));
         default: cols = 24'($urandom_range(1, 8));
      endcase
      case ($urandom_range(7))
         0:       total = 0;
         1:       total = 4096;
         2:       total = 13'h1FFF;
         3:       total = 24'($urandom_range(1, 4096));
         default: total = 24'($urandom_range(1, 30));
      endcase
      case ($urandom_range(7))
         0:       period = 0;
         1:       period = 24'hFFFFFF;
         2:       period = 24'($urandom);
         3:       period = 24'($urandom_range(41, 5000));
         default: period = 24'($urandom_range(1, 40));
      endcase
      w = 24'($urandom_range(0, 4095));
      h = 24'($urandom_range(0, 4095));
      junk = $urandom_range(1) ? 24'($urandom) : '0;
      write_config(cols | (junk & 24'hFFFE00), total | (junk & 24'hFFE000), period,
                   w | (junk & 24'hFFF000), h | (junk & 24'hFFF000),
                   24'($urandom_range(1)) | (junk & 24'hFFFFFE));
   endtask

   // Tick sizes spread around the frame period
   function automatic logic [23:0] pick_delta();
      longint unsigned p, d;
      p = (cfg_period == 0) ? 1 : cfg_period;
      case ($urandom_range(5))
         0:       d = 0;
         1:       d = $urandom_range(0, p - 1);
         2:       d = p * $urandom_range(1, 4) + $urandom_range(0, 3);
         3:       d = $urandom;
         default: d = $urandom_range(1, 2 * p);
      endcase
      return d[23:0];
   endfunction

   // Mostly play-then-tick sequences, with stops and resets mixed in
   task automatic send_random_commands(input int count);
      int k, roll;
      for (k = 0; k < count; k++) begin
         roll = $urandom_range(99);
         if (!anim_running) begin
            if (roll < 70) send_command(sfs_pkg::OP_PLAY, 24'($urandom));
            else if (roll < 85) send_command(sfs_pkg::OP_TICK, pick_delta());
            else if (roll < 93) send_command(sfs_pkg::OP_STOP, 24'($urandom));
            else send_command(sfs_pkg::OP_RESET, 24'($urandom));
         end else begin
            if (roll < 80) send_command(sfs_pkg::OP_TICK, pick_delta());
            else if (roll < 88) send_command(sfs_pkg::OP_PLAY, 24'($urandom));
            else if (roll < 95) send_command(sfs_pkg::OP_STOP, 24'($urandom));
            else send_command(sfs_pkg::OP_RESET, 24'($urandom));
         end
      end
   endtask

   // Response check and ready generation
   always @(posedge clock) begin : rsp_monitor
      frame_result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[57:0];
         if (frame_results_due.size() == 0) begin
            $error("response beat with nothing outstanding: frame_index %0d",
                   got.frame_index);
            error_count++;
         end else begin
            want = frame_results_due.pop_front();
            if (got.frame_index !== want.frame_index) begin
               $error("frame_index: expected %0d, got %0d", want.frame_index,
                      got.frame_index);
               error_count++;
            end
            if (got.rect_left !== want.rect_left) begin
               $error("rect_left: expected %0d, got %0d", want.rect_left,
                      got.rect_left);
               error_count++;
            end
            if (got.rect_top !== want.rect_top) begin
               $error("rect_top: expected %0d, got %0d", want.rect_top, got.rect_top);
               error_count++;
            end
            if (got.playing !== want.playing) begin
               $error("playing: expected %0d, got %0d", want.playing, got.playing);
               error_count++;
            end
            if (got.frame_changed !== want.frame_changed) begin
               $error("frame_changed: expected %0d, got %0d", want.frame_changed,
                      got.frame_changed);
               error_count++;
            end
         end
      end
      if (rsp_hold_cycles != 0) begin
         rsp_tready      <= 1'b0;
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Commands with the register values left by reset
   task automatic test_idle_commands();
      send_command(sfs_pkg::OP_TICK, 24'd0);
      send_command(sfs_pkg::OP_TICK, 24'hFFFFFF);   // stopped: no change
      send_command(sfs_pkg::OP_PLAY, 24'hFFFFFF);
      send_command(sfs_pkg::OP_TICK, 24'd0);        // zero delta: no change
      send_command(sfs_pkg::OP_TICK, 24'd1);        // single frame: clamps and stops
      wait_results_drained();
   endtask

   // Non-looping playback through a 12-frame sheet of 5 columns
   task automatic test_playback();
      write_config(5, 12, 100, 4095, 4095, 0);
      send_command(sfs_pkg::OP_PLAY, 24'd0);
      send_command(sfs_pkg::OP_TICK, 24'd99);
      send_command(sfs_pkg::OP_TICK, 24'd1);
      send_command(sfs_pkg::OP_TICK, 24'd250);
      send_command(sfs_pkg::OP_STOP, 24'd0);
      send_command(sfs_pkg::OP_TICK, 24'd500);      // stopped: elapsed kept
      send_command(sfs_pkg::OP_PLAY, 24'd0);
      send_command(sfs_pkg::OP_TICK, 24'hFFFFFF);   // runs off the end
      send_command(sfs_pkg::OP_RESET, 24'hABCDEF);
      wait_results_drained();
   endtask

   // Looping wraps, including one that lands on the same frame
   task automatic test_looping();
      write_register(sfs_pkg::CSR_LOOP_ENABLE, 1);
      send_command(sfs_pkg::OP_PLAY, 24'd0);
      send_command(sfs_pkg::OP_TICK, 24'd1200);     // whole cycle: same frame
      send_command(sfs_pkg::OP_TICK, 24'd350);
      send_command(sfs_pkg::OP_TICK, 24'hFFFFFF);
      wait_results_drained();
   endtask

   // Frame index left at or past a shrunken frame total
   task automatic test_frame_past_total();
      write_config(256, 4096, 1, 4095, 4095, 0);
      send_command(sfs_pkg::OP_PLAY, 24'd0);
      send_command(sfs_pkg::OP_TICK, 24'd4000);
      wait_results_drained();
      write_register(sfs_pkg::CSR_FRAME_TOTAL, 10);
      send_command(sfs_pkg::OP_TICK, 24'd1);        // clamps to the last frame
      wait_results_drained();
      write_register(sfs_pkg::CSR_FRAME_TOTAL, 4096);
      write_register(sfs_pkg::CSR_LOOP_ENABLE, 1);
      send_command(sfs_pkg::OP_PLAY, 24'd0);
      send_command(sfs_pkg::OP_TICK, 24'd3000);
      wait_results_drained();
      write_register(sfs_pkg::CSR_FRAME_TOTAL, 10);
      send_command(sfs_pkg::OP_TICK, 24'd5);        // restarts from frame 0
      wait_results_drained();
   endtask

   // Zero registers count as 1, a total above the frame range is limited
   task automatic test_zero_registers();
      write_config(0, 0, 0, 0, 4095, 1);
      write_register(CSR_UNMAPPED, 24'h5A5A5A);
      send_command(sfs_pkg::OP_TICK, 24'd7);
      wait_results_drained();
      write_register(sfs_pkg::CSR_FRAME_TOTAL, 24'hFFFFFF);   // 13-bit field reads 8191
      send_command(sfs_pkg::OP_TICK, 24'd5000);
      send_command(sfs_pkg::OP_RESET, 24'd0);
      wait_results_drained();
   endtask

   // Response side held off while commands keep coming
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_config(3, 20, 3, 17, 9, 1);
      rsp_hold_cycles <= 600;
      send_command(sfs_pkg::OP_PLAY, 24'd0);
      send_random_commands(30);
      wait_results_drained();
   endtask

   // Random phases rotating through the idling patterns
   task automatic test_random_phases();
      int phase;
      for (phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 63; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 63; end
            default: begin send_idle_pct = 13; rsp_stall_pct = 13; end
         endcase
         if (phase == 0) write_config(256, 4096, 24'hFFFFFF, 4095, 4095, 1);
         else if (phase == 1) write_config(1, 1, 1, 1, 1, 0);
         else load_random_config();
         send_random_commands(60);
         wait_results_drained();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_commands();
      test_playback();
      test_looping();
      test_frame_past_total();
      test_zero_registers();
      test_backpressure();
      test_random_phases();
      wait_results_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0 && frame_results_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/sfs_pkg.sv
sv/sfs_divider.sv
sv/sfs_multiplier.sv
sv/sprite_frame_sequencer_top.sv
sv/sfs_checker.sv
test/tb_sprite_frame_sequencer_top.sv
